// ===== hdl/jtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP controller package
// Shared types and constants for the sampled-pin TAP controller.
// ----------------------------------------------------------------------------
package jtc_pkg;

  typedef enum logic [3:0] {
    TAP_RESET     = 4'd0,
    TAP_IDLE      = 4'd1,
    TAP_DR_SELECT = 4'd2,
    TAP_DR_CAPTURE = 4'd3,
    TAP_DR_SHIFT  = 4'd4,
    TAP_DR_EXIT1  = 4'd5,
    TAP_DR_PAUSE  = 4'd6,
    TAP_DR_EXIT2  = 4'd7,
    TAP_DR_UPDATE = 4'd8,
    TAP_IR_SELECT = 4'd9,
    TAP_IR_CAPTURE = 4'd10,
    TAP_IR_SHIFT  = 4'd11,
    TAP_IR_EXIT1  = 4'd12,
    TAP_IR_PAUSE  = 4'd13,
    TAP_IR_EXIT2  = 4'd14,
    TAP_IR_UPDATE = 4'd15
  } tap_state_e;

  localparam int unsigned IrWidth   = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned LenWidth  = 6;

  localparam logic [DataWidth-1:0] DeviceIdReset = 32'h89BE_EF01;
  localparam logic [DataWidth-1:0] BsrPattern    = 32'hF0F0_F0F0;
  localparam logic [DataWidth-1:0] UnknownData   = 32'hDEAD_BEEF;

  localparam logic [IrWidth-1:0] IrBypass = 16'hFFFF;
  localparam logic [IrWidth-1:0] IrIdcode = 16'd4;
  localparam logic [IrWidth-1:0] IrExtest = 16'd0;
  localparam logic [IrWidth-1:0] IrSample = 16'd5;

  localparam logic [LenWidth-1:0] FullLen   = 6'd32;
  localparam logic [LenWidth-1:0] BypassLen = 6'd1;

  typedef struct packed {
    logic test_clock;
    logic mode_select;
    logic serial_in;
  } jtc_in_t;

  typedef struct packed {
    logic       serial_out;
    tap_state_e tap_state;
  } jtc_out_t;

endpackage

// ===== hdl/jtag_tap_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP controller unit
// Sampled-pin TAP controller with instruction and data scan registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one sample of
//   the TCK, TMS and TDI pins per transaction. Every input transaction yields
//   exactly one output transaction (out_valid_o / out_stall_i / out_data_o)
//   holding the TDO level and the TAP state after that sample.
//   From acceptance to result a transaction passes an input register, then
//   the state machine step feeding the result register.
//   Throughput is one transaction per cycle unless the receiver stalls; the TAP
//   state update is a single short step between the input and result registers.
//   When the receiver stalls, the result register holds; in_stall_o rises in
//   the same cycle once the input register holds a transaction, so at most
//   one more transaction is taken while the result waits.
//   device_id is written through cfg_we_i / cfg_wdata_i while idle.
//   Reset clears both pipeline registers, sets the TAP to Test-Logic-Reset,
//   the instruction to bypass and device_id to its default value.
// ----------------------------------------------------------------------------
module jtag_tap_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  jtc_pkg::jtc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output jtc_pkg::jtc_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [jtc_pkg::DataWidth-1:0] cfg_wdata_i
);
  import jtc_pkg::*;

  logic                 in_valid_q;
  jtc_in_t              in_data_q;
  logic                 out_valid_q;
  jtc_out_t             out_data_q;
  jtc_out_t             result;
  logic [DataWidth-1:0] device_id_q;
  logic                 out_free;
  logic                 step;
  logic                 in_take;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign step       = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= DeviceIdReset;
    end else if (cfg_we_i) begin
      device_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_data_q <= in_data_i;
    if (step) out_data_q <= result;
  end

  jtc_tap_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .sample_i    (in_data_q),
    .device_id_i (device_id_q),
    .result_o    (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/jtc_tap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP controller core
// TAP state machine, instruction and data scan registers; one pin sample per
// step, result presented combinationally for the output register.
// ----------------------------------------------------------------------------
module jtc_tap_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  jtc_pkg::jtc_in_t              sample_i,
  input  logic [jtc_pkg::DataWidth-1:0] device_id_i,
  output jtc_pkg::jtc_out_t             result_o
);
  import jtc_pkg::*;

  tap_state_e               state_q, state_d;
  logic                     last_clock_q, last_clock_d;
  logic [IrWidth-1:0]       instr_q, instr_d;
  logic [DataWidth-1:0]     data_q, data_d;
  logic [LenWidth-1:0]      len_q, len_d;
  logic                     out_bit_q, out_bit_d;
  logic                     rising;
  logic [$clog2(DataWidth)-1:0] top_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= TAP_RESET;
      last_clock_q <= 1'b0;
      instr_q      <= IrBypass;
      data_q       <= '0;
      len_q        <= BypassLen;
      out_bit_q    <= 1'b0;
    end else if (step_i) begin
      state_q      <= state_d;
      last_clock_q <= last_clock_d;
      instr_q      <= instr_d;
      data_q       <= data_d;
      len_q        <= len_d;
      out_bit_q    <= out_bit_d;
    end
  end

  assign rising       = sample_i.test_clock & ~last_clock_q;
  assign last_clock_d = sample_i.test_clock;
  assign top_pos      = len_q[$clog2(DataWidth)-1:0] - 1'b1;

  always_comb begin
    state_d   = state_q;
    instr_d   = instr_q;
    data_d    = data_q;
    len_d     = len_q;
    out_bit_d = out_bit_q;
    if (rising) begin
      unique case (state_q)
        TAP_RESET: begin
          if (!sample_i.mode_select) begin
            state_d = TAP_IDLE;
            instr_d = IrIdcode;
            data_d  = device_id_i;
            len_d   = FullLen;
          end
        end
        TAP_IDLE: begin
          if (sample_i.mode_select) state_d = TAP_DR_SELECT;
        end
        TAP_DR_SELECT: begin
          state_d = sample_i.mode_select ? TAP_IR_SELECT : TAP_DR_CAPTURE;
        end
        TAP_DR_CAPTURE: begin
          state_d = sample_i.mode_select ? TAP_DR_EXIT1 : TAP_DR_SHIFT;
        end
        TAP_DR_SHIFT: begin
          out_bit_d = data_q[0];
          data_d    = data_q >> 1;
          if (sample_i.serial_in) data_d[top_pos] = 1'b1;
          if (sample_i.mode_select) state_d = TAP_DR_EXIT1;
        end
        TAP_DR_EXIT1: begin
          state_d = sample_i.mode_select ? TAP_DR_UPDATE : TAP_DR_PAUSE;
        end
        TAP_DR_PAUSE: begin
          if (sample_i.mode_select) state_d = TAP_DR_EXIT2;
        end
        TAP_DR_EXIT2: begin
          state_d = sample_i.mode_select ? TAP_DR_UPDATE : TAP_DR_SHIFT;
        end
        TAP_DR_UPDATE: begin
          state_d = sample_i.mode_select ? TAP_DR_SELECT : TAP_IDLE;
        end
        TAP_IR_SELECT: begin
          state_d = sample_i.mode_select ? TAP_RESET : TAP_IR_CAPTURE;
        end
        TAP_IR_CAPTURE: begin
          state_d = sample_i.mode_select ? TAP_IR_EXIT1 : TAP_IR_SHIFT;
        end
        TAP_IR_SHIFT: begin
          out_bit_d = instr_q[0];
          instr_d   = {sample_i.serial_in, instr_q[IrWidth-1:1]};
          if (sample_i.mode_select) state_d = TAP_IR_EXIT1;
        end
        TAP_IR_EXIT1: begin
          state_d = sample_i.mode_select ? TAP_IR_UPDATE : TAP_IR_PAUSE;
        end
        TAP_IR_PAUSE: begin
          if (sample_i.mode_select) state_d = TAP_IR_EXIT2;
        end
        TAP_IR_EXIT2: begin
          state_d = sample_i.mode_select ? TAP_IR_UPDATE : TAP_IR_SHIFT;
        end
        TAP_IR_UPDATE: begin
          // decode the instruction into the selected data register
          len_d = FullLen;
          if (instr_q == IrBypass) begin
            data_d = '0;
            len_d  = BypassLen;
          end else if (instr_q == IrIdcode) begin
            data_d = device_id_i;
          end else if (instr_q == IrExtest || instr_q == IrSample) begin
            data_d = BsrPattern;
          end else begin
            data_d = UnknownData;
          end
          state_d = sample_i.mode_select ? TAP_DR_SELECT : TAP_IDLE;
        end
        default: state_d = TAP_RESET;
      endcase
    end
  end

  assign result_o.serial_out = out_bit_d;
  assign result_o.tap_state  = state_d;

endmodule

// ===== hdl/jtc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP controller port checker
// Port-level properties of the TAP controller unit, bound to the top level.
// ----------------------------------------------------------------------------
module jtc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input jtc_pkg::jtc_out_t             out_data_o
);
  import jtc_pkg::*;

  logic out_fire;
  assign out_fire = out_valid_o & ~out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted transaction produced no result");

  a_reset_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_data_o.tap_state == TAP_RESET ##1 out_fire |->
      out_data_o.tap_state == TAP_RESET || out_data_o.tap_state == TAP_IDLE)
    else $error("illegal transition out of Test-Logic-Reset");

  a_tdo_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire ##1 (out_fire && out_data_o.serial_out != $past(out_data_o.serial_out)) |->
      $past(out_data_o.tap_state) == TAP_DR_SHIFT ||
      $past(out_data_o.tap_state) == TAP_IR_SHIFT)
    else $error("TDO changed outside a shift state");

endmodule

bind jtag_tap_controller_unit jtc_checker u_jtc_checker (.*);

// ===== tb/sv/tb_jtag_tap_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TAP controller unit testbench
// Feeds sampled TCK/TMS/TDI pins as IR loads, DR scans, TMS resets, random
// state walks and glitchy pin noise. A scoreboard predicts TDO and the TAP
// state for every transaction and checks each result in order, while the
// sender gaps and the receiver stalls at random. device_id is rewritten
// between phases once all results have drained.
// ----------------------------------------------------------------------------
module tb_jtag_tap_controller_unit;
  import jtc_pkg::*;

  localparam int unsigned HalfPeriod    = 6;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ItemTarget    = 1900;
  localparam int unsigned CfgInterval   = 350;
  localparam int unsigned MaxReported   = 10;

  class tap_scoreboard;
    logic [DataWidth-1:0] device_id;
    tap_state_e           state;
    logic                 last_tck;
    logic [IrWidth-1:0]   instr;
    logic [DataWidth-1:0] data_reg;
    logic [LenWidth-1:0]  data_len;
    logic                 tdo;
    jtc_out_t             expected_q[$];
    int unsigned          mismatches;
    int unsigned          checked;

    function new();
      device_id  = DeviceIdReset;
      state      = TAP_RESET;
      last_tck   = 1'b0;
      instr      = IrBypass;
      data_reg   = '0;
      data_len   = BypassLen;
      tdo        = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void select_data(logic [DataWidth-1:0] value, logic [LenWidth-1:0] len);
      data_reg = value;
      data_len = len;
    endfunction

    function void advance(logic tms, logic tdi);
      logic [4:0] top;
      top = 5'(data_len - 6'd1);
      case (state)
        TAP_RESET: begin
          if (!tms) begin
            state = TAP_IDLE;
            instr = IrIdcode;
            select_data(device_id, FullLen);
          end
        end
        TAP_IDLE:       if (tms) state = TAP_DR_SELECT;
        TAP_DR_SELECT:  state = tms ? TAP_IR_SELECT : TAP_DR_CAPTURE;
        TAP_DR_CAPTURE: state = tms ? TAP_DR_EXIT1 : TAP_DR_SHIFT;
        TAP_DR_SHIFT: begin
          tdo      = data_reg[0];
          data_reg = data_reg >> 1;
          if (tdi) data_reg[top] = 1'b1;
          if (tms) state = TAP_DR_EXIT1;
        end
        TAP_DR_EXIT1:   state = tms ? TAP_DR_UPDATE : TAP_DR_PAUSE;
        TAP_DR_PAUSE:   if (tms) state = TAP_DR_EXIT2;
        TAP_DR_EXIT2:   state = tms ? TAP_DR_UPDATE : TAP_DR_SHIFT;
        TAP_DR_UPDATE:  state = tms ? TAP_DR_SELECT : TAP_IDLE;
        TAP_IR_SELECT:  state = tms ? TAP_RESET : TAP_IR_CAPTURE;
        TAP_IR_CAPTURE: state = tms ? TAP_IR_EXIT1 : TAP_IR_SHIFT;
        TAP_IR_SHIFT: begin
          tdo   = instr[0];
          instr = {tdi, instr[IrWidth-1:1]};
          if (tms) state = TAP_IR_EXIT1;
        end
        TAP_IR_EXIT1:   state = tms ? TAP_IR_UPDATE : TAP_IR_PAUSE;
        TAP_IR_PAUSE:   if (tms) state = TAP_IR_EXIT2;
        TAP_IR_EXIT2:   state = tms ? TAP_IR_UPDATE : TAP_IR_SHIFT;
        default: begin
          if (instr == IrBypass) select_data('0, BypassLen);
          else if (instr == IrIdcode) select_data(device_id, FullLen);
          else if (instr == IrExtest || instr == IrSample) select_data(BsrPattern, FullLen);
          else select_data(UnknownData, FullLen);
          state = tms ? TAP_DR_SELECT : TAP_IDLE;
        end
      endcase
    endfunction

    function void note_input(jtc_in_t pins);
      jtc_out_t result;
      if (pins.test_clock && !last_tck) advance(pins.mode_select, pins.serial_in);
      last_tck          = pins.test_clock;
      result.serial_out = tdo;
      result.tap_state  = state;
      expected_q.push_back(result);
    endfunction

    function void check_result(jtc_out_t got);
      jtc_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected result %0d: tdo=%b state=%0d", checked, got.serial_out,
                   got.tap_state);
        return;
      end
      want = expected_q.pop_front();
      if (got.serial_out !== want.serial_out || got.tap_state !== want.tap_state) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("result %0d mismatch: expected tdo=%b state=%0d, got tdo=%b state=%0d",
                   checked, want.serial_out, want.tap_state, got.serial_out, got.tap_state);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  jtc_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  jtc_out_t             out_data;
  logic                 cfg_we;
  logic [DataWidth-1:0] cfg_wdata;

  tap_scoreboard sb;
  bit            steady_phase = 1'b0;
  bit            glitch_en    = 1'b0;
  int unsigned   samples_sent = 0;
  int unsigned   stuck_cycles = 0;
  int unsigned   ir_loads     = 0;
  int unsigned   dr_scans     = 0;
  int unsigned   id_writes    = 0;

  jtag_tap_controller_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #HalfPeriod clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !steady_phase && ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic rbit();
    return 1'($urandom);
  endfunction

  task automatic send_sample(input jtc_in_t pins);
    while (!steady_phase && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pins;
    do @(posedge clk); while (in_stall);
    sb.note_input(pins);
    samples_sent++;
    steady_phase = (samples_sent >= 800 && samples_sent < 1100);
  endtask

  // One TCK period: a low sample, then the rising one; glitches repeat a level.
  task automatic clock_pin(input logic tms, input logic tdi);
    jtc_in_t pins;
    pins = '{1'b0, rbit(), rbit()};
    send_sample(pins);
    if (glitch_en && $urandom_range(99) < 8) begin
      pins = '{1'b0, rbit(), rbit()};
      send_sample(pins);
    end
    pins = '{1'b1, tms, tdi};
    send_sample(pins);
    if (glitch_en && $urandom_range(99) < 8) begin
      pins = '{1'b1, rbit(), rbit()};
      send_sample(pins);
    end
  endtask

  task automatic walk_to_idle();
    while (sb.state != TAP_IDLE) begin
      case (sb.state)
        TAP_RESET, TAP_DR_SELECT, TAP_DR_UPDATE, TAP_IR_SELECT, TAP_IR_UPDATE: begin
          clock_pin(1'b0, rbit());
        end
        default: begin
          clock_pin(1'b1, rbit());
        end
      endcase
    end
  endtask

  // Shift n bits LSB first; the last one leaves through Exit1.
  task automatic shift_bits(input int unsigned n, input logic [63:0] bits);
    for (int unsigned i = 0; i < n; i++) clock_pin(i == n - 1, bits[i]);
  endtask

  task automatic close_scan();
    if ($urandom_range(99) < 30) begin
      clock_pin(1'b0, rbit());
      repeat ($urandom_range(3)) clock_pin(1'b0, rbit());
      clock_pin(1'b1, rbit());
      if ($urandom_range(1)) begin
        clock_pin(1'b0, rbit());
        shift_bits($urandom_range(1, 6), {$urandom, $urandom});
      end
    end
    clock_pin(1'b1, rbit());
    clock_pin(rbit(), rbit());
  endtask

  task automatic load_instruction(input logic [IrWidth-1:0] code, input int unsigned n);
    walk_to_idle();
    clock_pin(1'b1, rbit());
    clock_pin(1'b1, rbit());
    clock_pin(1'b0, rbit());
    clock_pin(1'b0, rbit());
    shift_bits(n, {$urandom, 16'($urandom), code});
    close_scan();
    ir_loads++;
  endtask

  task automatic scan_data(input int unsigned n);
    walk_to_idle();
    clock_pin(1'b1, rbit());
    clock_pin(1'b0, rbit());
    clock_pin(1'b0, rbit());
    shift_bits(n, {$urandom, $urandom});
    close_scan();
    dr_scans++;
  endtask

  task automatic write_device_id(input logic [DataWidth-1:0] value);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.device_id = value;
    id_writes++;
  endtask

  initial begin
    jtc_in_t              pins;
    logic [IrWidth-1:0]   code;
    logic [DataWidth-1:0] id_value;
    int unsigned          roll;
    int unsigned          len;
    int unsigned          cfg_round;
    int unsigned          next_cfg_at;

    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    pins = '{1'b1, 1'b1, 1'b1};
    send_sample(pins);
    pins = '{1'b1, 1'b0, 1'b0};
    send_sample(pins);
    pins = '{1'b0, 1'b1, 1'b1};
    send_sample(pins);
    pins = '{1'b0, 1'b0, 1'b0};
    send_sample(pins);
    clock_pin(1'b0, 1'b0);
    clock_pin(1'b1, 1'b0);
    clock_pin(1'b1, 1'b1);
    clock_pin(1'b1, 1'b0);
    clock_pin(1'b0, 1'b1);
    clock_pin(1'b1, 1'b0);
    clock_pin(1'b0, 1'b0);
    clock_pin(1'b0, 1'b1);
    clock_pin(1'b0, 1'b1);
    clock_pin(1'b1, 1'b0);
    clock_pin(1'b1, 1'b1);
    clock_pin(1'b0, 1'b0);

    write_device_id('0);
    glitch_en   = 1'b1;
    cfg_round   = 0;
    next_cfg_at = CfgInterval;

    while (samples_sent < ItemTarget) begin
      if (samples_sent >= next_cfg_at) begin
        case (cfg_round % 4)
          0: id_value = '1;
          1: id_value = $urandom;
          2: id_value = DeviceIdReset;
          default: id_value = '0;
        endcase
        write_device_id(id_value);
        load_instruction(IrIdcode, IrWidth);
        scan_data(DataWidth);
        cfg_round++;
        next_cfg_at += CfgInterval;
      end
      roll = $urandom_range(99);
      if (roll < 35) begin
        case ($urandom_range(4))
          0: code = IrBypass;
          1: code = IrIdcode;
          2: code = IrExtest;
          3: code = IrSample;
          default: code = 16'($urandom);
        endcase
        len = ($urandom_range(99) < 85) ? IrWidth : $urandom_range(1, 24);
        load_instruction(code, len);
      end else if (roll < 75) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: len = $urandom_range(1, 8);
          5, 6, 7: len = DataWidth;
          default: len = $urandom_range(1, 40);
        endcase
        scan_data(len);
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 12)) clock_pin(rbit(), rbit());
      end else if (roll < 90) begin
        repeat (5) clock_pin(1'b1, rbit());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          pins = jtc_in_t'(3'($urandom));
          send_sample(pins);
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.mismatches += sb.expected_q.size();
    $display("Checked %0d results over %0d pin samples: %0d IR loads, %0d DR scans,",
             sb.checked, samples_sent, ir_loads, dr_scans);
    $display("%0d device_id writes, plus TMS resets, state walks and pin glitches.",
             id_writes);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/jtc_pkg.sv
hdl/jtc_tap_core.sv
hdl/jtag_tap_controller_unit.sv
hdl/jtc_checker.sv
tb/sv/tb_jtag_tap_controller_unit.sv
